@@ design/positional_sequence_list_defines.svh @@
// ----------------------------------------------------------------------------
// positional_sequence_list_defines
// Assertion macros used by the checker file of the list block.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_SEQUENCE_LIST_DEFINES_SVH
`define POSITIONAL_SEQUENCE_LIST_DEFINES_SVH

// same-cycle implication, disabled in reset
`define PSL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define PSL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/psl_pkg.sv @@
// ----------------------------------------------------------------------------
// psl_pkg
// Types, codes and widths of the positional sequence list.
// ----------------------------------------------------------------------------
`default_nettype none

package psl_pkg;

  localparam int WORD_W    = 32;
  localparam int KIND_W    = 3;
  localparam int POS_W     = 7;
  localparam int COUNT_W   = 7;
  localparam int STATUS_W  = 2;
  localparam int DEPTH_DEF = 64;
  localparam int GROUP     = 8;

  typedef enum logic [KIND_W-1:0] {
    K_READ   = 3'd0,
    K_WRITE  = 3'd1,
    K_INSERT = 3'd2,
    K_DELETE = 3'd3,
    K_PUSH   = 3'd4,
    K_POP    = 3'd5,
    K_CLEAR  = 3'd6
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_POS   = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    C_NONE,
    C_READ,
    C_WRITE,
    C_INSERT,
    C_DELETE,
    C_PUSH,
    C_POP,
    C_CLEAR
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    logic [WORD_W-1:0] value;
  } cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SUM,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

@@ design/positional_sequence_list.sv @@
// ----------------------------------------------------------------------------
// positional_sequence_list
// Ordered list of signed words by 1-based position, also usable as a stack.
// ----------------------------------------------------------------------------
//  channel | handshake           | beat fields
//  --------+---------------------+------------------------------
//  in      | in_valid / in_ready | kind, position, value
//  out     | out_valid/out_ready | data_out, count, status
//
//  The result is registered in two OR levels: the cell row and the
//  first OR level register at the input beat, the second OR level registers
//  in the next cycle and drives the output.
//  One item is in flight at a time; in_ready is low until the result is taken,
//  so a new item is taken only after the result of the last one is taken.
//  Reset clears every cell and the fill count.
//  A stalled output holds its beat and the cell row.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_sequence_list
  import psl_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic        [KIND_W-1:0]   kind,
  input  wire logic        [POS_W-1:0]    position,
  input  wire logic signed [WORD_W-1:0]   value,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic signed      [WORD_W-1:0]   data_out,
  output logic             [COUNT_W-1:0]  count,
  output logic             [STATUS_W-1:0] status
);

  localparam int AW = $clog2(DEPTH + 1);
  localparam int XW = ((AW > POS_W) ? AW : POS_W) + 1;

  state_t state, state_next;
  logic   acc;
  logic   sum;

  logic [AW-1:0]  fill;
  logic [XW-1:0]  fill_x;
  logic [XW-1:0]  pos_x;
  logic [XW-1:0]  depth_x;
  logic [XW-1:0]  fn_x;
  logic [AW-1:0]  tgt_d;
  logic           pos_nz;
  logic           in_list;
  logic           full;
  cell_op_t       op_d;
  status_t        st_d;
  cmd_t           cmd;

  logic [WORD_W-1:0] q    [DEPTH];
  logic [WORD_W-1:0] taps [DEPTH];
  logic [WORD_W-1:0] word;

  assign fill_x  = XW'(fill);
  assign pos_x   = XW'(position);
  assign depth_x = XW'(DEPTH);
  assign pos_nz  = (position != '0);
  assign in_list = pos_nz && (pos_x <= fill_x);
  assign full    = (fill_x >= depth_x);
  assign tgt_d   = pos_nz ? AW'(pos_x - XW'(1)) : '0;

  // decode the operation and its legality
  always_comb begin
    op_d = C_NONE;
    st_d = ST_OK;
    fn_x = fill_x;
    unique case (kind_t'(kind))
      K_READ: begin
        if (in_list) begin
          op_d = C_READ;
        end else begin
          st_d = ST_POS;
        end
      end
      K_WRITE: begin
        if (pos_nz && pos_x <= depth_x) begin
          op_d = C_WRITE;
          if (pos_x > fill_x) begin
            fn_x = pos_x;
          end
        end else begin
          st_d = ST_POS;
        end
      end
      K_INSERT: begin
        if (full) begin
          st_d = ST_FULL;
        end else if (pos_nz && pos_x <= fill_x + XW'(1)) begin
          op_d = C_INSERT;
          fn_x = fill_x + XW'(1);
        end else begin
          st_d = ST_POS;
        end
      end
      K_DELETE: begin
        if (in_list) begin
          op_d = C_DELETE;
          fn_x = fill_x - XW'(1);
        end else begin
          st_d = ST_POS;
        end
      end
      K_PUSH: begin
        if (full) begin
          st_d = ST_FULL;
        end else begin
          op_d = C_PUSH;
          fn_x = fill_x + XW'(1);
        end
      end
      K_POP: begin
        if (fill == '0) begin
          st_d = ST_EMPTY;
        end else begin
          op_d = C_POP;
          fn_x = fill_x - XW'(1);
        end
      end
      K_CLEAR: begin
        op_d = C_CLEAR;
        fn_x = '0;
      end
      default: begin
        op_d = C_NONE;
      end
    endcase
  end

  assign cmd.op    = acc ? op_d : C_NONE;
  assign cmd.value = value;

  // cell row
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_W-1:0] lower;
    logic [WORD_W-1:0] upper;
    if (i == 0) begin : g_lo0
      assign lower = '0;
    end else begin : g_lo
      assign lower = q[i-1];
    end
    if (i == DEPTH - 1) begin : g_hi0
      assign upper = '0;
    end else begin : g_hi
      assign upper = q[i+1];
    end
    psl_cell #(
      .INDEX (i),
      .AW    (AW)
    ) u_cell (
      .clk   (clk),
      .rst   (rst),
      .cmd   (cmd),
      .tgt   (tgt_d),
      .fill  (fill),
      .lower (lower),
      .upper (upper),
      .q     (q[i]),
      .tap   (taps[i])
    );
  end

  psl_gather #(
    .DEPTH (DEPTH)
  ) u_gather (
    .clk  (clk),
    .load (acc),
    .sum  (sum),
    .taps (taps),
    .word (word)
  );

  assign data_out = $signed(word);

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_SUM;
        end
      end
      S_SUM: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready  = (state == S_IDLE);
    sum       = (state == S_SUM);
    out_valid = (state == S_DONE);
  end

  assign acc = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill  <= '0;
    end else begin
      state <= state_next;
      if (acc) begin
        fill <= fn_x[AW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      count  <= fn_x[COUNT_W-1:0];
      status <= st_d;
    end
  end

endmodule

`default_nettype wire

@@ design/psl_cell.sv @@
// ----------------------------------------------------------------------------
// psl_cell
// One list entry: holds, loads, takes a neighbor's word or clears on command.
// ----------------------------------------------------------------------------
`default_nettype none

module psl_cell
  import psl_pkg::*;
#(
  parameter int INDEX = 0,
  parameter int AW    = 7
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cmd_t              cmd,
  input  wire logic [AW-1:0]     tgt,
  input  wire logic [AW-1:0]     fill,
  input  wire logic [WORD_W-1:0] lower,
  input  wire logic [WORD_W-1:0] upper,
  output logic      [WORD_W-1:0] q,
  output logic      [WORD_W-1:0] tap
);

  localparam logic [AW:0] ME  = (AW+1)'(INDEX);
  localparam logic [AW:0] ME1 = (AW+1)'(INDEX + 1);

  logic [AW:0]       e_tgt;
  logic [AW:0]       e_fill;
  logic [WORD_W-1:0] q_next;
  logic              pick;

  assign e_tgt  = {1'b0, tgt};
  assign e_fill = {1'b0, fill};

  always_comb begin
    q_next = q;
    pick   = 1'b0;
    case (cmd.op)
      C_READ: begin
        pick = (ME == e_tgt);
      end
      C_WRITE: begin
        if (ME == e_tgt) begin
          q_next = cmd.value;
        end else if (ME >= e_fill && ME < e_tgt) begin
          q_next = '0;
        end
      end
      C_INSERT: begin
        if (ME == e_tgt) begin
          q_next = cmd.value;
        end else if (ME > e_tgt && ME <= e_fill) begin
          q_next = lower;
        end
      end
      C_DELETE: begin
        if (ME1 == e_fill) begin
          q_next = '0;
        end else if (ME >= e_tgt && ME1 < e_fill) begin
          q_next = upper;
        end
      end
      C_PUSH: begin
        if (ME == e_fill) begin
          q_next = cmd.value;
        end
      end
      C_POP: begin
        pick = (ME1 == e_fill);
        if (ME1 == e_fill) begin
          q_next = '0;
        end
      end
      C_CLEAR: begin
        q_next = '0;
      end
      default: begin
        q_next = q;
      end
    endcase
  end

  // present the old word to the gather tree
  assign tap = pick ? q : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else begin
      q <= q_next;
    end
  end

endmodule

`default_nettype wire

@@ design/psl_gather.sv @@
// ----------------------------------------------------------------------------
// psl_gather
// Two-level registered OR tree collecting the one selected cell word.
// ----------------------------------------------------------------------------
`default_nettype none

module psl_gather
  import psl_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              load,
  input  wire logic              sum,
  input  wire logic [WORD_W-1:0] taps [DEPTH],
  output logic      [WORD_W-1:0] word
);

  localparam int NGRP = (DEPTH + GROUP - 1) / GROUP;

  logic [WORD_W-1:0] pad [NGRP*GROUP];
  logic [WORD_W-1:0] grp [NGRP];
  logic [WORD_W-1:0] grp_next [NGRP];
  logic [WORD_W-1:0] word_next;

  for (genvar p = 0; p < NGRP*GROUP; p++) begin : g_pad
    if (p < DEPTH) begin : g_tap
      assign pad[p] = taps[p];
    end else begin : g_zero
      assign pad[p] = '0;
    end
  end

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_next[g] = '0;
      for (int k = 0; k < GROUP; k++) begin
        grp_next[g] = grp_next[g] | pad[g*GROUP + k];
      end
    end
  end

  always_comb begin
    word_next = '0;
    for (int g = 0; g < NGRP; g++) begin
      word_next = word_next | grp[g];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      grp <= grp_next;
    end
    if (sum) begin
      word <= word_next;
    end
  end

endmodule

`default_nettype wire

@@ design/psl_checker.sv @@
// ----------------------------------------------------------------------------
// psl_checker
// Port-level checks of the positional sequence list, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "positional_sequence_list_defines.svh"

module psl_checker
  import psl_pkg::*;
(
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic        [KIND_W-1:0]   kind,
  input wire logic        [POS_W-1:0]    position,
  input wire logic signed [WORD_W-1:0]   value,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic signed [WORD_W-1:0]   data_out,
  input wire logic        [COUNT_W-1:0]  count,
  input wire logic        [STATUS_W-1:0] status
);

  logic in_beat;
  logic out_hold;
  logic in_seen;

  assign in_beat  = in_valid && in_ready;
  assign out_hold = out_valid && !out_ready;
  assign in_seen  = (kind != '0) || (position != '0) || (value != '0) || 1'b1;

  `PSL_ASSERT_NEXT(a_out_hold, clk, rst, out_hold, out_valid && $stable(data_out) && $stable(count) && $stable(status), "output beat changed while stalled")

  `PSL_ASSERT_NEXT(a_one_in_flight, clk, rst, in_beat && in_seen, !in_ready, "input taken while an item is in flight")

  `PSL_ASSERT_NOW(a_flag_no_data, clk, rst, out_valid && (status != ST_OK), data_out == '0, "flagged result carries data")

  `PSL_ASSERT_NOW(a_empty_pop, clk, rst, out_valid && (status == ST_EMPTY), count == '0, "pop on empty with nonzero count")

endmodule

bind positional_sequence_list psl_checker u_psl_checker (.*);

`default_nettype wire

@@ tb/tb_positional_sequence_list.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_positional_sequence_list
// Drives list operations over the valid/ready input channel and checks every
// output beat against a shadow list kept in the testbench. A short table of
// directed operations covers the empty and full edges, bad positions and the
// unused kind. Random segments that grow, shrink or mix the list follow, with
// bursty input and a patterned or random output stall.
// ----------------------------------------------------------------------------
module tb_positional_sequence_list;
  import psl_pkg::*;

  localparam int LIST_DEPTH   = DEPTH_DEF;
  localparam int RANDOM_ITEMS = 400;
  localparam int IDLE_LIMIT   = 1000;
  localparam int DRAIN_CYCLES = 16;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;

  typedef struct packed {
    logic signed [WORD_W-1:0]  data;
    logic        [COUNT_W-1:0] count;
    status_t                   status;
  } list_result_t;

  typedef struct packed {
    logic        [KIND_W-1:0] kind;
    logic        [POS_W-1:0]  pos;
    logic signed [WORD_W-1:0] value;
    bit                       typed;
    list_result_t             res;
  } dir_row_t;

  logic                       clk       = 1'b0;
  logic                       rst       = 1'b1;
  logic                       in_valid  = 1'b0;
  logic                       in_ready;
  logic        [KIND_W-1:0]   kind      = '0;
  logic        [POS_W-1:0]    position  = '0;
  logic signed [WORD_W-1:0]   value     = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [WORD_W-1:0]   data_out;
  logic        [COUNT_W-1:0]  count;
  logic        [STATUS_W-1:0] status;

  logic signed [WORD_W-1:0] list_mem [LIST_DEPTH];
  int                       list_fill;

  list_result_t expected_q [$];
  dir_row_t     dir_rows   [$];
  list_result_t checked_exp;

  int fail_count   = 0;
  int items_sent   = 0;
  int results_seen = 0;
  int n_full       = 0;
  int n_badpos     = 0;
  int n_empty      = 0;
  int peak_fill    = 0;
  int burst_left   = 0;
  int idle_cycles  = 0;
  int rdy_phase    = 0;
  int rdy_mode     = 0;

  positional_sequence_list #(.DEPTH(LIST_DEPTH)) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .position  (position),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .data_out  (data_out),
    .count     (count),
    .status    (status)
  );

  always #6 clk = ~clk;

  function automatic list_result_t apply_list_op(input logic [KIND_W-1:0] k,
                                                 input logic [POS_W-1:0] p,
                                                 input logic signed [WORD_W-1:0] v);
    list_result_t r;
    int ip;
    ip       = p;
    r.data   = '0;
    r.status = ST_OK;
    case (k)
      K_READ: begin
        if (ip >= 1 && ip <= list_fill) r.data = list_mem[ip-1];
        else r.status = ST_POS;
      end
      K_WRITE: begin
        if (ip >= 1 && ip <= LIST_DEPTH) begin
          for (int i = list_fill; i + 1 < ip; i++) list_mem[i] = '0;
          if (ip > list_fill) list_fill = ip;
          list_mem[ip-1] = v;
        end else begin
          r.status = ST_POS;
        end
      end
      K_INSERT: begin
        if (list_fill >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else if (ip >= 1 && ip <= list_fill + 1) begin
          for (int i = list_fill; i >= ip; i--) list_mem[i] = list_mem[i-1];
          list_mem[ip-1] = v;
          list_fill++;
        end else begin
          r.status = ST_POS;
        end
      end
      K_DELETE: begin
        if (ip >= 1 && ip <= list_fill) begin
          for (int i = ip; i < list_fill; i++) list_mem[i-1] = list_mem[i];
          list_mem[list_fill-1] = '0;
          list_fill--;
        end else begin
          r.status = ST_POS;
        end
      end
      K_PUSH: begin
        if (list_fill >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          list_mem[list_fill] = v;
          list_fill++;
        end
      end
      K_POP: begin
        if (list_fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.data = list_mem[list_fill-1];
          list_mem[list_fill-1] = '0;
          list_fill--;
        end
      end
      K_CLEAR: begin
        for (int i = 0; i < LIST_DEPTH; i++) list_mem[i] = '0;
        list_fill = 0;
      end
      default: ;
    endcase
    r.count = COUNT_W'(list_fill);
    return r;
  endfunction

  task automatic add_row(input logic [KIND_W-1:0] k, input logic [POS_W-1:0] p,
                         input logic signed [WORD_W-1:0] v, input bit typed,
                         input logic signed [WORD_W-1:0] d, input int c,
                         input status_t s);
    dir_row_t row;
    row.kind       = k;
    row.pos        = p;
    row.value      = v;
    row.typed      = typed;
    row.res.data   = d;
    row.res.count  = COUNT_W'(c);
    row.res.status = s;
    dir_rows.push_back(row);
  endtask

  // hold the beat until it is taken
  task automatic send_beat(input logic [KIND_W-1:0] k, input logic [POS_W-1:0] p,
                           input logic signed [WORD_W-1:0] v);
    in_valid <= 1'b1;
    kind     <= k;
    position <= p;
    value    <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic record_op(input logic [KIND_W-1:0] k, input logic [POS_W-1:0] p,
                           input logic signed [WORD_W-1:0] v, input bit typed,
                           input list_result_t typed_res);
    list_result_t r;
    r = apply_list_op(k, p, v);
    if (list_fill > peak_fill) peak_fill = list_fill;
    expected_q.push_back(typed ? typed_res : r);
  endtask

  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                : $urandom_range(0, 12);
    end
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [KIND_W-1:0] pick_kind(input int mode);
    int r;
    logic [KIND_W-1:0] k;
    r = $urandom_range(0, 99);
    case (mode)
      0: begin
        if (r < 35) k = K_PUSH;
        else if (r < 60) k = K_INSERT;
        else if (r < 80) k = K_WRITE;
        else if (r < 90) k = K_READ;
        else if (r < 94) k = K_DELETE;
        else if (r < 97) k = K_POP;
        else if (r < 98) k = K_CLEAR;
        else k = KIND_UNUSED;
      end
      1: begin
        if (r < 35) k = K_POP;
        else if (r < 65) k = K_DELETE;
        else if (r < 80) k = K_READ;
        else if (r < 85) k = K_WRITE;
        else if (r < 90) k = K_PUSH;
        else if (r < 95) k = K_INSERT;
        else if (r < 98) k = K_CLEAR;
        else k = KIND_UNUSED;
      end
      default: begin
        k = KIND_W'($urandom_range(0, 7));
        if (k == K_CLEAR && $urandom_range(0, 3) != 0) k = K_READ;
      end
    endcase
    return k;
  endfunction

  function automatic logic [POS_W-1:0] pick_position();
    int r;
    int hi;
    r  = $urandom_range(0, 99);
    hi = (list_fill + 3 > LIST_DEPTH) ? LIST_DEPTH : list_fill + 3;
    if (r < 75) return POS_W'($urandom_range(1, hi));
    if (r < 85) return POS_W'($urandom_range(0, 127));
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return POS_W'(list_fill);
      2:       return POS_W'(list_fill + 1);
      3:       return POS_W'(LIST_DEPTH);
      default: return POS_W'(LIST_DEPTH + 1);
    endcase
  endfunction

  function automatic logic signed [WORD_W-1:0] pick_value();
    if ($urandom_range(0, 99) < 15) begin
      case ($urandom_range(0, 3))
        0:       return 32'h7FFF_FFFF;
        1:       return 32'h8000_0000;
        2:       return 32'h0000_0000;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    return $urandom;
  endfunction

  always @(posedge clk) begin
    rdy_phase <= rdy_phase + 1;
    if (rdy_phase % 64 == 0) rdy_mode <= $urandom_range(0, 3);
    case (rdy_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= 1'($urandom_range(0, 1));
      2:       out_ready <= (rdy_phase % 4 == 3);
      default: out_ready <= (rdy_phase % 16 > 11);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        $error("unexpected result beat: data_out %0d count %0d status %0d",
               data_out, count, status);
        fail_count++;
      end else begin
        checked_exp = expected_q.pop_front();
        case (checked_exp.status)
          ST_FULL:  n_full++;
          ST_POS:   n_badpos++;
          ST_EMPTY: n_empty++;
          default:  ;
        endcase
        if (data_out !== checked_exp.data) begin
          $error("data_out mismatch: expected %0d, got %0d", checked_exp.data, data_out);
          fail_count++;
        end
        if (count !== checked_exp.count) begin
          $error("count mismatch: expected %0d, got %0d", checked_exp.count, count);
          fail_count++;
        end
        if (status !== checked_exp.status) begin
          $error("status mismatch: expected %0d, got %0d", checked_exp.status, status);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    dir_row_t            row;
    logic [KIND_W-1:0]   k;
    logic [POS_W-1:0]    p;
    logic signed [WORD_W-1:0] v;
    int                  mode;
    int                  segment_left;

    for (int i = 0; i < LIST_DEPTH; i++) list_mem[i] = '0;
    list_fill    = 0;
    mode         = 2;
    segment_left = 0;

    add_row(K_READ,      7'd1,   32'sd0,        1, 32'sd0,        0,  ST_POS);
    add_row(K_POP,       7'd0,   32'sd0,        1, 32'sd0,        0,  ST_EMPTY);
    add_row(K_DELETE,    7'd1,   32'sd0,        1, 32'sd0,        0,  ST_POS);
    add_row(K_INSERT,    7'd2,   32'sd5,        1, 32'sd0,        0,  ST_POS);
    add_row(K_WRITE,     7'd0,   32'sd9,        1, 32'sd0,        0,  ST_POS);
    add_row(K_WRITE,     7'd127, 32'sd9,        1, 32'sd0,        0,  ST_POS);
    add_row(KIND_UNUSED, 7'd127, 32'hFFFF_FFFF, 1, 32'sd0,        0,  ST_OK);
    add_row(K_PUSH,      7'd0,   32'h7FFF_FFFF, 1, 32'sd0,        1,  ST_OK);
    add_row(K_PUSH,      7'd0,   32'h8000_0000, 1, 32'sd0,        2,  ST_OK);
    add_row(K_READ,      7'd1,   32'sd0,        1, 32'h7FFF_FFFF, 2,  ST_OK);
    add_row(K_READ,      7'd2,   32'sd0,        1, 32'h8000_0000, 2,  ST_OK);
    add_row(K_READ,      7'd3,   32'sd0,        1, 32'sd0,        2,  ST_POS);
    add_row(K_WRITE,     7'd5,   32'hFFFF_FFFF, 0, 32'sd0,        0,  ST_OK);
    add_row(K_READ,      7'd4,   32'sd0,        0, 32'sd0,        0,  ST_OK);
    add_row(K_INSERT,    7'd1,   32'h1234_5678, 0, 32'sd0,        0,  ST_OK);
    add_row(K_INSERT,    7'd7,   32'hA5A5_A5A5, 0, 32'sd0,        0,  ST_OK);
    add_row(K_DELETE,    7'd2,   32'sd0,        0, 32'sd0,        0,  ST_OK);
    add_row(K_READ,      7'd0,   32'sd0,        0, 32'sd0,        0,  ST_OK);
    add_row(K_POP,       7'd0,   32'sd0,        0, 32'sd0,        0,  ST_OK);
    add_row(K_CLEAR,     7'd0,   32'sd0,        1, 32'sd0,        0,  ST_OK);
    add_row(K_WRITE,     7'd64,  32'h5555_5555, 1, 32'sd0,        64, ST_OK);
    add_row(K_PUSH,      7'd0,   32'sd1,        1, 32'sd0,        64, ST_FULL);
    add_row(K_INSERT,    7'd0,   32'sd1,        1, 32'sd0,        64, ST_FULL);
    add_row(K_READ,      7'd64,  32'sd0,        1, 32'h5555_5555, 64, ST_OK);
    add_row(K_DELETE,    7'd64,  32'sd0,        0, 32'sd0,        0,  ST_OK);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      send_beat(row.kind, row.pos, row.value);
      record_op(row.kind, row.pos, row.value, row.typed, row.res);
      pace_sender();
    end
    wait_all_results();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (segment_left == 0) begin
        mode         = $urandom_range(0, 2);
        segment_left = $urandom_range(15, 60);
      end
      segment_left--;
      k = pick_kind(mode);
      p = pick_position();
      v = pick_value();
      send_beat(k, p, v);
      record_op(k, p, v, 1'b0, '0);
      pace_sender();
      if (n == RANDOM_ITEMS / 2) wait_all_results();
    end

    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d operations, checked %0d results, peak fill %0d of %0d.",
             items_sent, results_seen, peak_fill, LIST_DEPTH);
    $display("Flagged results: %0d full, %0d bad position, %0d empty pop.",
             n_full, n_badpos, n_empty);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
